@@ sv/cid_pkg.sv @@
// ----------------------------------------------------------------------------
// cid_pkg: shared types and constants of the crash impact detector
// Field widths, register indexes, reset values, score constants and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cid_pkg;

	localparam int HISTORY_DEPTH = 20;
	localparam int POST_DEPTH    = 20;

	localparam int MAG_W     = 16;
	localparam int THR_W     = 15;
	localparam int SCORE_W   = 11;
	localparam int CNT_W     = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMPACT_THR      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FREE_FALL_THR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_THR      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOOKBACK_COUNT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT      = 3'd5;

	localparam logic [MAG_W-1:0]        CAL_OFFSET_RST    = 16'd0;
	localparam logic [THR_W-1:0]        IMPACT_THR_RST    = 15'd5120;
	localparam logic signed [MAG_W-1:0] FREE_FALL_THR_RST = -16'sd1792;
	localparam logic [THR_W-1:0]        STABLE_THR_RST    = 15'd512;
	localparam logic [CNT_W-1:0]        LOOKBACK_RST      = 5'd10;
	localparam logic [CNT_W-1:0]        SKIP_RST          = 5'd3;

	localparam logic [SCORE_W-1:0] SCORE_MAX    = 11'd2047;
	localparam logic [SCORE_W-1:0] ADD_PRE_FALL = 11'd102;
	localparam logic [SCORE_W-1:0] ADD_POST     = 11'd154;
	localparam logic [SCORE_W-1:0] ALERT_LEVEL  = 11'd128;

	// excess / 100 as (excess * DIV_MUL) >> DIV_SHIFT, exact for 15-bit excess
	localparam int              PROD_W    = 31;
	localparam int              DIV_SHIFT = 22;
	localparam logic [15:0]     DIV_MUL   = 16'd41944;

	typedef struct packed {
		logic load;
		logic post_write;
		logic pscan_start;
		logic post_finish;
		logic check;
		logic mul;
		logic impact_start;
		logic pre_add;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic impact;
		logic post_full;
		logic scan_busy;
		logic start_ok;
		logic out_free;
	} sts_t;

	function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
			input logic [SCORE_W-1:0] b);
		logic [SCORE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SCORE_W] ? SCORE_MAX : s[SCORE_W-1:0];
	endfunction

endpackage

@@ sv/cid_ifs.sv @@
// ----------------------------------------------------------------------------
// cid_ifs: channel interfaces of the crash impact detector
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface cid_sample_if;
	logic                       valid;
	logic                       ready;
	logic [cid_pkg::MAG_W-1:0]  magnitude;

	modport source(output valid, output magnitude, input ready);
	modport sink(input valid, input magnitude, output ready);
endinterface

interface cid_result_if;
	logic                        valid;
	logic                        ready;
	logic                        crash_alert;
	logic [cid_pkg::SCORE_W-1:0] score;
	logic                        impact_active;
	logic                        analysis_done;

	modport source(output valid, output crash_alert, output score, output impact_active,
		output analysis_done, input ready);
	modport sink(input valid, input crash_alert, input score, input impact_active,
		input analysis_done, output ready);
endinterface

interface cid_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [cid_pkg::CFG_IDX_W-1:0] index;
	logic [cid_pkg::CFG_DAT_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ sv/cid_ctrl.sv @@
// ----------------------------------------------------------------------------
// cid_ctrl: sequencing state machine of the crash impact detector
// Steps one item through post store or analysis, history update, impact
// start, history scan and result hand-off.
// ----------------------------------------------------------------------------
module cid_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cid_pkg::sts_t sts,
	output cid_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EVAL   = 4'd1;
	localparam logic [3:0] S_PSCAN  = 4'd2;
	localparam logic [3:0] S_PFIN   = 4'd3;
	localparam logic [3:0] S_CHECK  = 4'd4;
	localparam logic [3:0] S_DECIDE = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_RSCAN  = 4'd7;
	localparam logic [3:0] S_RADD   = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.impact && !sts.post_full) begin
					cmd.post_write = 1'b1;
					state_d        = S_CHECK;
				end else if (sts.impact) begin
					cmd.pscan_start = 1'b1;
					state_d         = S_PSCAN;
				end else begin
					state_d = S_CHECK;
				end
			end
			S_PSCAN: begin
				if (!sts.scan_busy) state_d = S_PFIN;
			end
			S_PFIN: begin
				cmd.post_finish = 1'b1;
				state_d         = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.start_ok) begin
					cmd.mul = 1'b1;
					state_d = S_DIV;
				end else begin
					state_d = S_OUT;
				end
			end
			S_DIV: begin
				cmd.impact_start = 1'b1;
				state_d          = S_RSCAN;
			end
			S_RSCAN: begin
				if (!sts.scan_busy) state_d = S_RADD;
			end
			S_RADD: begin
				cmd.pre_add = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

@@ sv/cid_dp.sv @@
// ----------------------------------------------------------------------------
// cid_dp: datapath of the crash impact detector
// Configuration registers, calibration, history ring and post window
// memories, the shared scan unit, score arithmetic and the output register.
// ----------------------------------------------------------------------------
module cid_dp #(
	parameter int HISTORY_DEPTH = cid_pkg::HISTORY_DEPTH,
	parameter int POST_DEPTH    = cid_pkg::POST_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cid_pkg::cmd_t                   cmd,
	output cid_pkg::sts_t                   sts,
	input  logic [cid_pkg::MAG_W-1:0]       in_magnitude,
	input  logic                            cfg_we,
	input  logic [cid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cid_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic                            out_crash_alert,
	output logic [cid_pkg::SCORE_W-1:0]     out_score,
	output logic                            out_impact_active,
	output logic                            out_analysis_done
);

	localparam int HAW = $clog2(HISTORY_DEPTH);
	localparam int HCW = $clog2(HISTORY_DEPTH + 1);
	localparam int PAW = $clog2(POST_DEPTH);
	localparam int PCW = $clog2(POST_DEPTH + 1);
	localparam int CW  = ((HCW > cid_pkg::CNT_W) ? HCW : cid_pkg::CNT_W) + 1;
	localparam int SW  = (PCW > cid_pkg::CNT_W) ? PCW : cid_pkg::CNT_W;
	localparam int LW  = (HCW > PCW) ? HCW : PCW;
	localparam int MW  = cid_pkg::MAG_W;

	localparam logic [HAW-1:0] WP_LAST = HAW'(HISTORY_DEPTH - 1);
	localparam logic [HCW-1:0] HD_N    = HCW'(HISTORY_DEPTH);
	localparam logic [PCW-1:0] PD_N    = PCW'(POST_DEPTH);
	localparam logic [HAW+1:0] HD_X    = (HAW+2)'(HISTORY_DEPTH);

	logic [MW-1:0]                   cal_q;
	logic [cid_pkg::THR_W-1:0]       imp_thr_q;
	logic signed [MW-1:0]            ff_thr_q;
	logic [cid_pkg::THR_W-1:0]       stab_thr_q;
	logic [cid_pkg::CNT_W-1:0]       lookback_q;
	logic [cid_pkg::CNT_W-1:0]       skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q      <= cid_pkg::CAL_OFFSET_RST;
			imp_thr_q  <= cid_pkg::IMPACT_THR_RST;
			ff_thr_q   <= cid_pkg::FREE_FALL_THR_RST;
			stab_thr_q <= cid_pkg::STABLE_THR_RST;
			lookback_q <= cid_pkg::LOOKBACK_RST;
			skip_q     <= cid_pkg::SKIP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cid_pkg::REG_CAL_OFFSET:     cal_q      <= cfg_data;
				cid_pkg::REG_IMPACT_THR:     imp_thr_q  <= cfg_data[cid_pkg::THR_W-1:0];
				cid_pkg::REG_FREE_FALL_THR:  ff_thr_q   <= signed'(cfg_data);
				cid_pkg::REG_STABLE_THR:     stab_thr_q <= cfg_data[cid_pkg::THR_W-1:0];
				cid_pkg::REG_LOOKBACK_COUNT: lookback_q <= cfg_data[cid_pkg::CNT_W-1:0];
				cid_pkg::REG_SKIP_COUNT:     skip_q     <= cfg_data[cid_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// calibrate with saturation to signed Q8.8
	logic signed [MW:0]   diff;
	logic signed [MW-1:0] m_next;
	logic signed [MW-1:0] m_q;

	always_comb begin
		diff = signed'({1'b0, in_magnitude}) - signed'({1'b0, cal_q});
		if (diff[MW] != diff[MW-1]) m_next = diff[MW] ? {1'b1, {(MW-1){1'b0}}}
			: {1'b0, {(MW-1){1'b1}}};
		else m_next = diff[MW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) m_q <= m_next;
	end

	logic signed [MW-1:0]           thr_s;
	logic [MW-1:0]                  excess;
	logic [cid_pkg::PROD_W-1:0]     prod_s1;
	logic [cid_pkg::SCORE_W-1:0]    quot;

	assign thr_s  = signed'({1'b0, imp_thr_q});
	assign excess = m_q - thr_s;
	assign quot   = cid_pkg::SCORE_W'(prod_s1[cid_pkg::PROD_W-1:cid_pkg::DIV_SHIFT]);

	always_ff @(posedge clk) begin
		if (cmd.mul) prod_s1 <= cid_pkg::PROD_W'(excess[cid_pkg::THR_W-1:0])
			* cid_pkg::PROD_W'(cid_pkg::DIV_MUL);
	end

	// state flags
	logic                        impact_q;
	logic                        fresh_q;
	logic                        coll_q;
	logic                        post_done_q;
	logic                        alert_q;
	logic                        done_q;
	logic [cid_pkg::SCORE_W-1:0] lik_q;
	logic [HAW-1:0]              wp_q;
	logic [HAW-1:0]              wp_next;
	logic [HISTORY_DEPTH-1:0]    ring_vld_q;
	logic [PCW-1:0]              post_cnt_q;
	logic                        stab_q;
	logic                        fall_q;
	logic [cid_pkg::SCORE_W-1:0] post_add;

	assign wp_next  = (wp_q == WP_LAST) ? '0 : wp_q + 1'b1;
	assign post_add = (stab_q ? cid_pkg::ADD_POST : '0) + (fall_q ? cid_pkg::ADD_POST : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			impact_q    <= 1'b0;
			fresh_q     <= 1'b1;
			coll_q      <= 1'b0;
			post_done_q <= 1'b0;
			alert_q     <= 1'b0;
			done_q      <= 1'b0;
			lik_q       <= '0;
			wp_q        <= '0;
			ring_vld_q  <= '0;
			post_cnt_q  <= '0;
		end else begin
			if (cmd.load) begin
				alert_q <= 1'b0;
				done_q  <= 1'b0;
			end
			if (cmd.post_write) post_cnt_q <= post_cnt_q + 1'b1;
			if (cmd.post_finish) begin
				lik_q       <= cid_pkg::sat_add(lik_q, post_add);
				impact_q    <= 1'b0;
				fresh_q     <= 1'b0;
				wp_q        <= '0;
				post_done_q <= 1'b1;
				done_q      <= 1'b1;
			end
			if (cmd.check) begin
				if (lik_q > cid_pkg::ALERT_LEVEL && !coll_q && post_done_q) begin
					coll_q  <= 1'b1;
					alert_q <= 1'b1;
				end
				if (!impact_q) begin
					ring_vld_q[wp_q] <= 1'b1;
					wp_q             <= wp_next;
					if (CW'(wp_next) > CW'(lookback_q)) fresh_q <= 1'b1;
				end
			end
			if (cmd.impact_start) begin
				lik_q       <= quot;
				coll_q      <= 1'b0;
				impact_q    <= 1'b1;
				post_done_q <= 1'b0;
				post_cnt_q  <= '0;
			end
			if (cmd.pre_add && fall_q) lik_q <= cid_pkg::sat_add(lik_q, cid_pkg::ADD_PRE_FALL);
		end
	end

	// memories
	logic signed [MW-1:0] ring_mem [HISTORY_DEPTH];
	logic signed [MW-1:0] post_mem [POST_DEPTH];
	logic signed [MW-1:0] ring_rd_s1;
	logic                 ring_ok_s1;
	logic signed [MW-1:0] post_rd_s1;

	// scan unit
	logic           scan_ring_q;
	logic [LW-1:0]  left_q;
	logic [HAW-1:0] raddr_q;
	logic [PAW-1:0] paddr_q;
	logic           issue;
	logic           rd_vld_s1;
	logic           rd_ring_s1;
	logic [PAW-1:0] ridx_s1;

	logic [HCW-1:0]       n_look;
	logic [HAW+1:0]       st_sum;
	logic [HAW-1:0]       ring_start;
	logic [cid_pkg::CNT_W-1:0] skip2;
	logic signed [MW-1:0] ring_v;
	logic signed [MW:0]   pv_x;
	logic [MW:0]          pv_abs;

	assign issue = (left_q != '0);

	always_comb begin
		n_look = (CW'(lookback_q) > CW'(HD_N)) ? HD_N : HCW'(lookback_q);
		st_sum = (HAW+2)'(wp_q) + HD_X - (HAW+2)'(n_look);
		ring_start = (st_sum >= HD_X) ? HAW'(st_sum - HD_X) : HAW'(st_sum);
		skip2  = (skip_q >= 5'd2) ? skip_q - 5'd2 : '0;
		ring_v = ring_ok_s1 ? ring_rd_s1 : '0;
		pv_x   = {post_rd_s1[MW-1], post_rd_s1};
		pv_abs = post_rd_s1[MW-1] ? unsigned'(-pv_x) : unsigned'(pv_x);
	end

	always_ff @(posedge clk) begin
		if (cmd.check && !impact_q) ring_mem[wp_q] <= m_q;
		if (issue && scan_ring_q) begin
			ring_rd_s1 <= ring_mem[raddr_q];
			ring_ok_s1 <= ring_vld_q[raddr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post_write) post_mem[post_cnt_q[PAW-1:0]] <= m_q;
		if (issue && !scan_ring_q) post_rd_s1 <= post_mem[paddr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_ring_q <= 1'b0;
			left_q      <= '0;
			raddr_q     <= '0;
			paddr_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rd_ring_s1  <= 1'b0;
			ridx_s1     <= '0;
			stab_q      <= 1'b1;
			fall_q      <= 1'b0;
		end else begin
			rd_vld_s1  <= issue;
			rd_ring_s1 <= scan_ring_q;
			ridx_s1    <= paddr_q;
			if (cmd.pscan_start) begin
				scan_ring_q <= 1'b0;
				left_q      <= LW'(POST_DEPTH);
				paddr_q     <= '0;
				stab_q      <= 1'b1;
				fall_q      <= 1'b0;
			end else if (cmd.impact_start) begin
				scan_ring_q <= 1'b1;
				left_q      <= LW'(n_look);
				raddr_q     <= ring_start;
				fall_q      <= 1'b0;
			end else begin
				if (issue) begin
					left_q <= left_q - 1'b1;
					if (scan_ring_q) raddr_q <= (raddr_q == WP_LAST) ? '0 : raddr_q + 1'b1;
					else paddr_q <= paddr_q + 1'b1;
				end
				if (rd_vld_s1) begin
					if (rd_ring_s1) begin
						if (ring_v < ff_thr_q) fall_q <= 1'b1;
					end else begin
						if (SW'(ridx_s1) >= SW'(skip_q)
								&& pv_abs > (MW+1)'(stab_thr_q)) stab_q <= 1'b0;
						if (SW'(ridx_s1) >= SW'(skip2) && post_rd_s1 < ff_thr_q)
							fall_q <= 1'b1;
					end
				end
			end
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_crash_alert   <= alert_q;
			out_score         <= lik_q;
			out_impact_active <= impact_q;
			out_analysis_done <= done_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.impact    = impact_q;
		sts.post_full = (post_cnt_q == PD_N);
		sts.scan_busy = issue || rd_vld_s1;
		sts.start_ok  = (m_q > thr_s) && !impact_q && fresh_q;
		sts.out_free  = !out_valid_q || out_ready;
	end

endmodule

@@ sv/crash_impact_detector.sv @@
// ----------------------------------------------------------------------------
// crash_impact_detector: collision detector on acceleration magnitude items
// Calibrates each sample, keeps a history ring and a post-impact window,
// scores an impact and raises a crash alert at most once per analyzed impact.
//
//   channel  role   handshake      payload
//   sample   sink   valid/ready    magnitude
//   result   source valid/ready    crash_alert, score, impact_active,
//                                  analysis_done
//   cfg      sink   valid/ready    index, data (ready always high)
//
// One item at a time. A plain sample passes evaluation, history update and
// the start decision before result load; a sample that starts an impact
// adds a history scan of lookback entries (at most HISTORY_DEPTH) on the
// single ring read port; an analyzing sample adds the post window scan of
// POST_DEPTH entries.
// The next sample is taken while the previous result waits in the output
// register; a stalled result holds the block before its next result load.
// Reset clears score, ring valid bits and flags, but sets fresh and stable.
// ----------------------------------------------------------------------------
module crash_impact_detector #(
	parameter int HISTORY_DEPTH = cid_pkg::HISTORY_DEPTH,
	parameter int POST_DEPTH    = cid_pkg::POST_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	cid_sample_if.sink    sample,
	cid_result_if.source  result,
	cid_cfg_if.sink       cfg
);

	cid_pkg::cmd_t cmd;
	cid_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	cid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cid_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.POST_DEPTH    (POST_DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.in_magnitude      (sample.magnitude),
		.cfg_we            (cfg.valid),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.out_ready         (result.ready),
		.out_valid         (result.valid),
		.out_crash_alert   (result.crash_alert),
		.out_score         (result.score),
		.out_impact_active (result.impact_active),
		.out_analysis_done (result.analysis_done)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("sample taken while an item is in flight");

	a_no_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready |-> !sts.scan_busy)
		else $error("scan still running while idle");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> result.valid)
		else $error("loaded result not presented");

endmodule
